/* sv/opr_pkg.sv */
`default_nettype none

package opr_pkg;

	// Widths of the configuration registers and the millisecond counters
	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned IDLE_MIN_W  = 10;
	localparam int unsigned IDLE_PROD_W = 26;
	localparam int unsigned CODE_W      = 3;

	localparam logic [CFG_W-1:0] MS_PER_MINUTE = 16'd60000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_HOLD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 2'd2;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] SEARCH_TIMEOUT_RST = 16'd5000;
	localparam logic [CFG_W-1:0] MOTION_HOLD_RST    = 16'd1000;
	localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST = 16'd500;

	typedef enum logic [CODE_W-1:0] {
		MODE_SEARCHING = 3'd0,
		MODE_CONNECTED = 3'd1,
		MODE_IDLE      = 3'd2,
		MODE_POWER_OFF = 3'd3,
		MODE_OVERRIDE  = 3'd4
	} mode_t;

	// Conditions handed from the timer block to the mode controller
	typedef struct packed {
		logic run;
		logic lost;
		logic still;
		logic idle_done;
		logic packet_ever;
	} timer_flags_t;

endpackage

`default_nettype wire

/* sv/opr_in_stage.sv */
`default_nettype none

module opr_in_stage (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   load,
	input  wire                                   advance,
	input  wire                                   packet_seen,
	input  wire                                   motion_seen,
	input  wire                                   override_on,
	input  wire  [opr_pkg::IDLE_MIN_W-1:0]        idle_minutes,
	output logic                                  valid_s1,
	output logic                                  packet_s1,
	output logic                                  motion_s1,
	output logic                                  override_s1,
	output logic [opr_pkg::IDLE_PROD_W-1:0]       idle_limit_s1
);
	import opr_pkg::*;

	// occupancy of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the word; convert the idle limit from minutes to ms here
	always_ff @(posedge clk) begin
		if (load) begin
			packet_s1     <= packet_seen;
			motion_s1     <= motion_seen;
			override_s1   <= override_on;
			idle_limit_s1 <= IDLE_PROD_W'(idle_minutes) * IDLE_PROD_W'(MS_PER_MINUTE);
		end
	end

endmodule

`default_nettype wire

/* sv/opr_timers.sv */
`default_nettype none

module opr_timers (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 step,
	input  wire                                 packet_s1,
	input  wire                                 motion_s1,
	input  wire  [opr_pkg::IDLE_PROD_W-1:0]     idle_limit_s1,
	input  wire  [opr_pkg::CFG_W-1:0]           search_timeout_ms,
	input  wire  [opr_pkg::CFG_W-1:0]           motion_hold_ms,
	input  wire  [opr_pkg::CFG_W-1:0]           check_interval_ticks,
	output opr_pkg::timer_flags_t               flags
);
	import opr_pkg::*;

	logic [CNT_W-1:0] pkt_cnt_q;
	logic [CNT_W-1:0] mot_cnt_q;
	logic             packet_ever_q;
	logic [CFG_W-1:0] ivl_cnt_q;

	logic [CNT_W-1:0] pkt_cnt_nxt;
	logic [CNT_W-1:0] mot_cnt_nxt;
	logic             packet_ever_nxt;
	logic [CFG_W:0]   ivl_inc;
	logic             run;
	logic [CFG_W-1:0] ivl_cnt_nxt;

	always_comb begin
		// clear on activity, else count and saturate
		if (packet_s1) begin
			pkt_cnt_nxt = '0;
		end else if (&pkt_cnt_q) begin
			pkt_cnt_nxt = pkt_cnt_q;
		end else begin
			pkt_cnt_nxt = pkt_cnt_q + 1'b1;
		end

		if (motion_s1) begin
			mot_cnt_nxt = '0;
		end else if (&mot_cnt_q) begin
			mot_cnt_nxt = mot_cnt_q;
		end else begin
			mot_cnt_nxt = mot_cnt_q + 1'b1;
		end

		packet_ever_nxt = packet_ever_q | packet_s1;

		// an interval of zero behaves as one
		ivl_inc     = {1'b0, ivl_cnt_q} + 1'b1;
		run         = (ivl_inc >= {1'b0, check_interval_ticks});
		ivl_cnt_nxt = run ? '0 : ivl_inc[CFG_W-1:0];
	end

	assign flags.run         = run;
	assign flags.lost        = (pkt_cnt_nxt > CNT_W'(search_timeout_ms));
	assign flags.still       = (mot_cnt_nxt > CNT_W'(motion_hold_ms));
	assign flags.idle_done   = (mot_cnt_nxt > CNT_W'(idle_limit_s1));
	assign flags.packet_ever = packet_ever_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_cnt_q     <= '0;
			mot_cnt_q     <= '0;
			packet_ever_q <= 1'b0;
			ivl_cnt_q     <= '0;
		end else if (step) begin
			pkt_cnt_q     <= pkt_cnt_nxt;
			mot_cnt_q     <= mot_cnt_nxt;
			packet_ever_q <= packet_ever_nxt;
			ivl_cnt_q     <= ivl_cnt_nxt;
		end
	end

`ifndef SYNTHESIS
	a_interval_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(step && run) |=> (ivl_cnt_q == '0))
		else $error("interval counter did not restart after an evaluation");
`endif

endmodule

`default_nettype wire

/* sv/opr_mode_fsm.sv */
`default_nettype none

module opr_mode_fsm (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire                              override_s1,
	input  opr_pkg::timer_flags_t            flags,
	output logic [opr_pkg::CODE_W-1:0]       state_code_nxt,
	output logic                             relay_nxt
);
	import opr_pkg::*;

	mode_t mode_q;
	mode_t mode_nxt;
	logic  relay_q;
	logic  linked;

	assign linked = flags.packet_ever && !flags.lost;

	// next state
	always_comb begin
		mode_nxt = mode_q;
		if (flags.run) begin
			case (mode_q)
				MODE_SEARCHING: begin
					if (linked) begin
						mode_nxt = MODE_CONNECTED;
					end else if (override_s1) begin
						mode_nxt = MODE_OVERRIDE;
					end
				end
				MODE_CONNECTED: begin
					if (flags.still) begin
						mode_nxt = MODE_IDLE;
					end else if (override_s1) begin
						mode_nxt = MODE_OVERRIDE;
					end else if (flags.lost) begin
						mode_nxt = MODE_SEARCHING;
					end
				end
				MODE_IDLE: begin
					if (!flags.still) begin
						mode_nxt = MODE_CONNECTED;
					end else if (flags.idle_done) begin
						mode_nxt = MODE_POWER_OFF;
					end else if (override_s1) begin
						mode_nxt = MODE_OVERRIDE;
					end else if (flags.lost) begin
						mode_nxt = MODE_SEARCHING;
					end
				end
				MODE_POWER_OFF: begin
					if (linked) begin
						if (!flags.still) begin
							mode_nxt = MODE_CONNECTED;
						end else if (override_s1) begin
							mode_nxt = MODE_OVERRIDE;
						end
					end else if (flags.lost) begin
						mode_nxt = MODE_SEARCHING;
					end
				end
				MODE_OVERRIDE: begin
					if (!override_s1) begin
						mode_nxt = flags.packet_ever ? MODE_CONNECTED : MODE_SEARCHING;
					end
				end
				default: begin
					mode_nxt = mode_q;
				end
			endcase
		end
	end

	// relay drive: close on entry to an active mode, open on search or power off
	always_comb begin
		relay_nxt = relay_q;
		if (flags.run && (mode_nxt != mode_q)) begin
			case (mode_nxt)
				MODE_SEARCHING: relay_nxt = 1'b0;
				MODE_POWER_OFF: relay_nxt = 1'b0;
				MODE_OVERRIDE:  relay_nxt = 1'b1;
				MODE_CONNECTED: relay_nxt = (mode_q == MODE_IDLE) ? relay_q : 1'b1;
				MODE_IDLE:      relay_nxt = relay_q;
				default:        relay_nxt = relay_q;
			endcase
		end
		state_code_nxt = mode_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SEARCHING;
			relay_q <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_nxt;
			relay_q <= relay_nxt;
		end
	end

`ifndef SYNTHESIS
	a_relay_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		relay_q == ((mode_q == MODE_CONNECTED) || (mode_q == MODE_IDLE) ||
			(mode_q == MODE_OVERRIDE)))
		else $error("relay drive disagrees with the mode");
	a_mode_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q))
		else $error("mode changed without a word in flight");
`endif

endmodule

`default_nettype wire

/* sv/occupancy_power_relay_fsm_top.sv */
// Occupancy power relay controller.
// Input channel (in_valid / in_stall): one word per millisecond tick with
// packet_seen, motion_seen, override_on and idle_minutes. Output channel
// (out_valid / out_stall): exactly one word per input word with state_code,
// relay_on and evaluated. state_code also selects the LED pattern.
// Configuration: write cfg_wdata to register cfg_index while cfg_wen is
// high; index 0 search timeout, 1 motion hold, 2 check interval. Writes to
// other indexes are dropped. Write only while no word is in flight.
// Flow: a word held in the input stage updates the counters and controller
// as it advances, on the same edge that loads its result into the output register.
// Throughput: one word per cycle while out_stall is low, set by the single
// input register and single output register around one pass of logic.
// Reset: counters and interval clear, mode goes to searching, relay opens,
// configuration returns to 5000 / 1000 / 500, both channels empty.
// Output stall: the result word holds; the input stage holds one more word
// and in_stall rises only once that stage is full too.
`default_nettype none

module occupancy_power_relay_fsm_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire                                packet_seen,
	input  wire                                motion_seen,
	input  wire                                override_on,
	input  wire  [opr_pkg::IDLE_MIN_W-1:0]     idle_minutes,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [opr_pkg::CODE_W-1:0]         state_code,
	output logic                               relay_on,
	output logic                               evaluated,
	input  wire                                cfg_wen,
	input  wire  [opr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [opr_pkg::CFG_W-1:0]          cfg_wdata
);
	import opr_pkg::*;

	logic [CFG_W-1:0] search_timeout_q;
	logic [CFG_W-1:0] motion_hold_q;
	logic [CFG_W-1:0] check_interval_q;

	logic                   valid_s1;
	logic                   packet_s1;
	logic                   motion_s1;
	logic                   override_s1;
	logic [IDLE_PROD_W-1:0] idle_limit_s1;

	logic                   out_free;
	logic                   step;
	logic                   load;
	timer_flags_t           flags;
	logic [CODE_W-1:0]      state_code_nxt;
	logic                   relay_nxt;

	logic                   out_valid_q;
	logic [CODE_W-1:0]      state_code_q;
	logic                   relay_on_q;
	logic                   evaluated_q;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_timeout_q <= SEARCH_TIMEOUT_RST;
			motion_hold_q    <= MOTION_HOLD_RST;
			check_interval_q <= CHECK_INTERVAL_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SEARCH_TIMEOUT: search_timeout_q <= cfg_wdata;
				REG_MOTION_HOLD:    motion_hold_q    <= cfg_wdata;
				REG_CHECK_INTERVAL: check_interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: the output register frees when empty or being taken,
	// the input stage advances into it whenever it is free
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load     = in_valid && !in_stall;

	opr_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.advance       (step),
		.packet_seen   (packet_seen),
		.motion_seen   (motion_seen),
		.override_on   (override_on),
		.idle_minutes  (idle_minutes),
		.valid_s1      (valid_s1),
		.packet_s1     (packet_s1),
		.motion_s1     (motion_s1),
		.override_s1   (override_s1),
		.idle_limit_s1 (idle_limit_s1)
	);

	opr_timers u_timers (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (step),
		.packet_s1            (packet_s1),
		.motion_s1            (motion_s1),
		.idle_limit_s1        (idle_limit_s1),
		.search_timeout_ms    (search_timeout_q),
		.motion_hold_ms       (motion_hold_q),
		.check_interval_ticks (check_interval_q),
		.flags                (flags)
	);

	opr_mode_fsm u_mode_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.override_s1    (override_s1),
		.flags          (flags),
		.state_code_nxt (state_code_nxt),
		.relay_nxt      (relay_nxt)
	);

	// result register: fill on step, drop when taken without a refill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			state_code_q <= state_code_nxt;
			relay_on_q   <= relay_nxt;
			evaluated_q  <= flags.run;
		end
	end

	assign out_valid  = out_valid_q;
	assign state_code = state_code_q;
	assign relay_on   = relay_on_q;
	assign evaluated  = evaluated_q;

`ifndef SYNTHESIS
	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("word advanced but no result was registered");
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while a stage was free");
`endif

endmodule

`default_nettype wire

/* tb/tb_occupancy_power_relay_fsm_top.sv */
`timescale 1ns / 1ps

module tb_occupancy_power_relay_fsm_top;
	import opr_pkg::*;

	// Index with no register behind it; the block must drop writes to it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		mode_t code;
		logic  relay;
		logic  ran;
	} relay_word_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  packet_seen = 1'b0;
	logic                  motion_seen = 1'b0;
	logic                  override_on = 1'b0;
	logic [IDLE_MIN_W-1:0] idle_minutes = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [CODE_W-1:0]     state_code;
	logic                  relay_on;
	logic                  evaluated;
	logic                  cfg_wen     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_W-1:0]      cfg_wdata   = '0;

	// Controller shadow: mirrors the block's counters, mode and registers
	mode_t             ctl_mode       = MODE_SEARCHING;
	logic [CNT_W-1:0]  pkt_age        = '0;
	logic [CNT_W-1:0]  motion_age     = '0;
	logic              seen_packet    = 1'b0;
	logic              relay_closed   = 1'b0;
	logic [CFG_W-1:0]  tick_count     = '0;
	logic [CFG_W-1:0]  timeout_ms     = SEARCH_TIMEOUT_RST;
	logic [CFG_W-1:0]  hold_ms        = MOTION_HOLD_RST;
	logic [CFG_W-1:0]  interval_ticks = CHECK_INTERVAL_RST;

	relay_word_t expected_words[$];
	int          mismatch_count = 0;
	// Largest random wait per word on each side; zero gives a stretch with no idling
	int          in_gap_max     = 0;
	int          out_gap_max    = 0;

	occupancy_power_relay_fsm_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packet_seen  (packet_seen),
		.motion_seen  (motion_seen),
		.override_on  (override_on),
		.idle_minutes (idle_minutes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.state_code   (state_code),
		.relay_on     (relay_on),
		.evaluated    (evaluated),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Advance the shadow by one millisecond tick and queue the word it yields.
	// Counters move first, so an evaluation on this tick sees the new ages.
	function automatic void predict_tick(input logic pkt, input logic mot, input logic ovr,
			input logic [IDLE_MIN_W-1:0] mins);
		logic [CFG_W:0]   next_count;
		logic [CNT_W-1:0] idle_limit;
		logic             lost;
		logic             still;
		logic             idle_done;
		logic             ran;
		relay_word_t      exp_w;
		if (pkt) begin
			pkt_age     = '0;
			seen_packet = 1'b1;
		end else if (pkt_age != '1) begin
			pkt_age = pkt_age + 1'b1;
		end
		if (mot) begin
			motion_age = '0;
		end else if (motion_age != '1) begin
			motion_age = motion_age + 1'b1;
		end

		// An interval of zero lands here on every tick, same as an interval of one
		next_count = {1'b0, tick_count} + 1'b1;
		ran        = next_count >= {1'b0, interval_ticks};
		if (ran) begin
			tick_count = '0;
			idle_limit = CNT_W'(mins) * CNT_W'(MS_PER_MINUTE);
			lost       = pkt_age > CNT_W'(timeout_ms);
			still      = motion_age > CNT_W'(hold_ms);
			idle_done  = motion_age > idle_limit;
			case (ctl_mode)
				MODE_SEARCHING: begin
					if (seen_packet && !lost) begin
						ctl_mode     = MODE_CONNECTED;
						relay_closed = 1'b1;
					end else if (ovr) begin
						ctl_mode     = MODE_OVERRIDE;
						relay_closed = 1'b1;
					end
				end
				MODE_CONNECTED: begin
					// Relay is left as is when connected hands over to idle or override
					if (still) begin
						ctl_mode = MODE_IDLE;
					end else if (ovr) begin
						ctl_mode = MODE_OVERRIDE;
					end else if (lost) begin
						ctl_mode     = MODE_SEARCHING;
						relay_closed = 1'b0;
					end
				end
				MODE_IDLE: begin
					if (!still) begin
						ctl_mode = MODE_CONNECTED;
					end else if (idle_done) begin
						ctl_mode     = MODE_POWER_OFF;
						relay_closed = 1'b0;
					end else if (ovr) begin
						ctl_mode     = MODE_OVERRIDE;
						relay_closed = 1'b1;
					end else if (lost) begin
						ctl_mode     = MODE_SEARCHING;
						relay_closed = 1'b0;
					end
				end
				MODE_POWER_OFF: begin
					if (seen_packet && !lost) begin
						if (!still) begin
							ctl_mode     = MODE_CONNECTED;
							relay_closed = 1'b1;
						end else if (ovr) begin
							ctl_mode     = MODE_OVERRIDE;
							relay_closed = 1'b1;
						end
					end else if (lost) begin
						ctl_mode     = MODE_SEARCHING;
						relay_closed = 1'b0;
					end
				end
				MODE_OVERRIDE: begin
					if (!ovr) begin
						if (seen_packet) begin
							ctl_mode = MODE_CONNECTED;
						end else begin
							ctl_mode     = MODE_SEARCHING;
							relay_closed = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end else begin
			tick_count = next_count[CFG_W-1:0];
		end
		exp_w.code  = ctl_mode;
		exp_w.relay = relay_closed;
		exp_w.ran   = ran;
		expected_words.push_back(exp_w);
	endfunction

	// Offer one tick word after a random gap, hold it until taken, then predict it
	task automatic send_tick(input logic pkt, input logic mot, input logic ovr,
			input logic [IDLE_MIN_W-1:0] mins);
		int gap;
		gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
		@(negedge clk);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		packet_seen  <= pkt;
		motion_seen  <= mot;
		override_on  <= ovr;
		idle_minutes <= mins;
		do @(posedge clk); while (in_stall);
		predict_tick(pkt, mot, ovr, mins);
	endtask

	// Drop valid and let every outstanding word come back, plus the pipe depth
	task automatic drain_words();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_SEARCH_TIMEOUT: timeout_ms     = value;
			REG_MOTION_HOLD:    hold_ms        = value;
			REG_CHECK_INTERVAL: interval_ticks = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] hold,
			input logic [CFG_W-1:0] interval);
		write_reg(REG_SEARCH_TIMEOUT, timeout);
		write_reg(REG_MOTION_HOLD, hold);
		write_reg(REG_CHECK_INTERVAL, interval);
	endtask

	// Mostly small thresholds so timeouts fire within a phase, now and then any value
	function automatic logic [CFG_W-1:0] pick_threshold();
		return ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 24));
	endfunction

	// Reset registers, no packet yet: the first check lands on tick 500 and takes
	// override; a ten-tick check then drops back to searching with the relay open,
	// since the link was never up
	task automatic test_before_first_packet();
		int i;
		in_gap_max  = 0;
		out_gap_max = 0;
		for (i = 0; i < 505; i++) begin
			send_tick(1'b0, 1'($urandom), (i >= 450), IDLE_MIN_W'($urandom));
		end
		drain_words();
		write_reg(REG_CHECK_INTERVAL, 16'd10);
		for (i = 0; i < 20; i++) begin
			send_tick(1'b0, 1'($urandom), 1'b0, IDLE_MIN_W'($urandom));
		end
		drain_words();
	endtask

	// Reset timeouts with a ten-tick check: connect on the first check once
	// packets flow
	task automatic test_default_timing();
		int i;
		for (i = 0; i < 40; i++) begin
			send_tick(1'b1, (i < 20) ? 1'($urandom) : 1'b0, 1'b0, '1);
		end
		drain_words();
	endtask

	// Zero timeouts and a zero interval: every tick is checked, a tick without a
	// packet is a lost link, a tick without motion is still (and idle done at 0 min)
	task automatic test_mode_walk();
		in_gap_max  = 14;
		out_gap_max = 14;
		set_config('0, '0, '0);
		write_reg(REG_UNUSED, '1);
		send_tick(1'b1, 1'b0, 1'b0, 10'd1023); // connected goes idle
		send_tick(1'b0, 1'b0, 1'b1, 10'd1023); // idle, override engaged
		send_tick(1'b0, 1'b0, 1'b0, 10'd0);    // override released, back to connected
		send_tick(1'b1, 1'b1, 1'b1, 10'd0);    // connected into override
		send_tick(1'b1, 1'b1, 1'b0, 10'd0);
		send_tick(1'b1, 1'b0, 1'b0, 10'd1023); // connected goes idle
		send_tick(1'b1, 1'b1, 1'b0, 10'd0);    // motion wakes it
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);    // idle limit reached, relay opens
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);    // power off holds while still
		send_tick(1'b1, 1'b0, 1'b1, 10'd1023); // power off into override
		send_tick(1'b1, 1'b0, 1'b0, 10'd5);
		send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
		send_tick(1'b1, 1'b0, 1'b1, 10'd1023); // idle into override
		send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
		send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
		send_tick(1'b0, 1'b0, 1'b0, 10'd1023); // idle loses the link
		send_tick(1'b0, 1'b1, 1'b0, 10'd1023); // searching stays while lost
		send_tick(1'b1, 1'b1, 1'b0, 10'd0);
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);
		send_tick(1'b1, 1'b1, 1'b0, 10'd0);    // power off back to connected
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);
		send_tick(1'b0, 1'b0, 1'b1, 10'd0);    // power off loses the link, override ignored
		send_tick(1'b0, 1'b1, 1'b1, 10'd0);    // searching into override
		send_tick(1'b1, 1'b1, 1'b0, 10'd1023);
		send_tick(1'b0, 1'b1, 1'b0, 10'd1023); // connected loses the link
		drain_words();
	endtask

	// Phases of segments: each segment holds a packet rate, a motion rate and an
	// override level, with a few stray override flips as noise
	task automatic test_random_traffic();
		int                    phase;
		int                    sent;
		int                    seg_len;
		int                    pkt_pct;
		int                    mot_pct;
		int                    mins_mode;
		logic                  ovr_level;
		logic [IDLE_MIN_W-1:0] mins;
		for (phase = 0; phase < 4; phase++) begin
			drain_words();
			if (phase == 0) begin
				set_config('1, '1, '1);
			end else if (phase == 1) begin
				set_config('0, '1, 16'd1);
			end else begin
				set_config(pick_threshold(), pick_threshold(),
					($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
			end
			in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 14;
			out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
			sent = 0;
			while (sent < 22) begin
				seg_len = $urandom_range(3, 20);
				case ($urandom_range(0, 3))
					0:       pkt_pct = 0;
					1:       pkt_pct = 60;
					default: pkt_pct = 100;
				endcase
				case ($urandom_range(0, 2))
					0:       mot_pct = 0;
					1:       mot_pct = 40;
					default: mot_pct = 100;
				endcase
				ovr_level = ($urandom_range(0, 3) == 0);
				mins_mode = $urandom_range(0, 2);
				repeat (seg_len) begin
					case (mins_mode)
						0:       mins = '0;
						1:       mins = '1;
						default: mins = IDLE_MIN_W'($urandom);
					endcase
					send_tick($urandom_range(0, 99) < pkt_pct, $urandom_range(0, 99) < mot_pct,
						ovr_level ^ ($urandom_range(0, 19) == 0), mins);
					sent++;
				end
			end
		end
		drain_words();
	endtask

	// One packet with motion, then silence: idle after the hold, power off on the
	// next check with a zero idle limit, searching once the search timeout runs out
	task automatic test_long_idle();
		int i;
		in_gap_max  = 0;
		out_gap_max = 0;
		set_config(16'd60, 16'd20, 16'd7);
		send_tick(1'b1, 1'b1, 1'b0, 10'd0);
		for (i = 0; i < 80; i++) begin
			send_tick(1'b0, 1'b0, 1'b0, 10'd0);
		end
		drain_words();
	endtask

	// Receiver: draw a stall length per result word, then take the word
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
			@(negedge clk);
			repeat (hold) begin
				out_stall <= 1'b1;
				@(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Compare every word taken on the output against the oldest prediction
	always @(posedge clk) begin : result_check
		relay_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing pending: state_code %0d", state_code);
				mismatch_count++;
			end else begin
				exp_w = expected_words.pop_front();
				if (state_code !== exp_w.code) begin
					$error("state_code: expected %0d, actual %0d", exp_w.code, state_code);
					mismatch_count++;
				end
				if (relay_on !== exp_w.relay) begin
					$error("relay_on: expected %0d, actual %0d", exp_w.relay, relay_on);
					mismatch_count++;
				end
				if (evaluated !== exp_w.ran) begin
					$error("evaluated: expected %0d, actual %0d", exp_w.ran, evaluated);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_before_first_packet();
		test_default_timing();
		test_mode_walk();
		test_random_traffic();
		test_long_idle();
		if (mismatch_count == 0) begin
			$display("occupancy_power_relay_fsm_top verification clean");
		end else begin
			$display("occupancy_power_relay_fsm_top verification failed");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#1_000_000;
		$display("occupancy_power_relay_fsm_top verification failed");
		$finish;
	end

endmodule

/* occupancy_power_relay_fsm_top.f */
sv/opr_pkg.sv
sv/opr_in_stage.sv
sv/opr_timers.sv
sv/opr_mode_fsm.sv
sv/occupancy_power_relay_fsm_top.sv
tb/tb_occupancy_power_relay_fsm_top.sv
